FILE: rtl/jbcd_pkg.sv
// shared types, constants and tables for the block coefficient decoder
package jbcd_pkg;

    localparam int BLOCK_SIDE    = 8;
    localparam int CHANNEL_COUNT = 4;
    localparam int QUANT_TABLES  = 4;
    localparam int COEFS         = BLOCK_SIDE * BLOCK_SIDE;

    localparam int POS_W   = 6;
    localparam int COEF_W  = 48;
    localparam int CHAN_W  = 2;
    localparam int SYM_W   = 8;
    localparam int AMP_W   = 15;
    localparam int TNUM_W  = 2;
    localparam int SLOT_W  = 6;
    localparam int WORD_W  = 16;
    localparam int PRED_W  = 32;
    localparam int EXT_W   = 16;
    localparam int QSEL_W  = 8;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 56;

    // largest amplitude size
    localparam logic [3:0] SIZE_MAX = 4'd15;

    // register map, index into the register list
    localparam logic REG_QUANT_SELECT = 1'b0;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_DECODE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FETCH,
        ST_EMIT,
        ST_EOB_FETCH,
        ST_EOB_EMIT,
        ST_ERROR
    } state_t;

    typedef struct packed {
        logic item_load;
        logic q_write;
        logic pred_clear;
        logic start_dc;
        logic start_ac;
        logic start_eob;
        logic emit;
        logic emit_err;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic is_eob;
        logic overrun;
        logic ch_ok;
        logic zeros_zero;
        logic count_last;
        logic out_free;
    } sts_t;

    localparam logic [POS_W-1:0] ZZ_TO_NAT [COEFS] = '{
        6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
        6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
        6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
        6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
    };

endpackage

FILE: rtl/jpeg_block_coefficient_decode.sv
// top level: stream ports, register port, controller and datapath
//
//  channel  | direction | transfer when            | contents
//  s_axis   | in        | tvalid & tready          | one operation item
//  m_axis   | out       | tvalid & tready          | one coefficient result
//  apb      | in/out    | psel & penable & pwrite  | quant_select at address 0
//
// load and clear items are taken in their transfer alone; a decode item has a transfer and a decode step,
// then a quantizer memory read and a multiply for each coefficient it produces
// an end-of-block can produce up to 63 coefficients
// the result register lets the next coefficient be computed while one waits;
// a stalled output holds the sequence in its multiply step
// reset clears predictors, block position and quant_select; no clearing pass
module jpeg_block_coefficient_decode (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // channel, symbol, amplitude, table_number, table_slot, table_word, zero pad
    input  logic [jbcd_pkg::S_DATA_W-1:0] s_axis_tdata,
    // operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // position, coefficient, component
    output logic [jbcd_pkg::M_DATA_W-1:0] m_axis_tdata,
    // error
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import jbcd_pkg::*;

    cmd_t                     cmd;
    sts_t                     sts;
    logic [QSEL_W-1:0]        quant_select_reg;
    logic [POS_W-1:0]         position;
    logic signed [COEF_W-1:0] coefficient;
    logic [CHAN_W-1:0]        component;
    logic                     last;
    logic                     error;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_select_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_QUANT_SELECT)
        begin
            quant_select_reg <= pwdata[QSEL_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_QUANT_SELECT)
        begin
            prdata = {{(32 - QSEL_W){1'b0}}, quant_select_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    jbcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    jbcd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .quant_select (quant_select_reg),
        .channel      (s_axis_tdata[1:0]),
        .symbol       (s_axis_tdata[9:2]),
        .amplitude    (s_axis_tdata[24:10]),
        .table_number (s_axis_tdata[26:25]),
        .table_slot   (s_axis_tdata[32:27]),
        .table_word   (s_axis_tdata[48:33]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .position     (position),
        .coefficient  (coefficient),
        .component    (component),
        .last         (last),
        .error        (error)
    );

    assign m_axis_tdata = {component, coefficient, position};
    assign m_axis_tuser = error;
    assign m_axis_tlast = last;

endmodule

FILE: rtl/jbcd_ctrl.sv
// controller state machine sequencing decode, expansion and result transfers
module jbcd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     in_op,
    input  jbcd_pkg::sts_t sts,
    output jbcd_pkg::cmd_t cmd
);
    import jbcd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(in_op))
                        OP_LOAD:   cmd.q_write = 1'b1;
                        OP_CLEAR:  cmd.pred_clear = 1'b1;
                        OP_DECODE:
                        begin
                            cmd.item_load = 1'b1;
                            state_next    = ST_DECODE;
                        end
                        default:   ;
                    endcase
                end
            end
            ST_DECODE:
            begin
                if (sts.count_zero)
                begin
                    if (sts.ch_ok)
                    begin
                        cmd.start_dc = 1'b1;
                        state_next   = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (sts.is_eob)
                begin
                    cmd.start_eob = 1'b1;
                    state_next    = ST_EOB_FETCH;
                end
                else if (sts.overrun)
                begin
                    state_next = ST_ERROR;
                end
                else
                begin
                    cmd.start_ac = 1'b1;
                    state_next   = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.zeros_zero ? ST_IDLE : ST_FETCH;
                end
            end
            ST_EOB_FETCH:
            begin
                state_next = ST_EOB_EMIT;
            end
            ST_EOB_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.count_last ? ST_IDLE : ST_EOB_FETCH;
                end
            end
            ST_ERROR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit && cmd.emit_err))
        else $error("two results loaded in one cycle");

    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.emit_err) |-> sts.out_free)
        else $error("result loaded over an untaken result");

    a_decode_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_op == OP_DECODE) |=> state_reg == ST_DECODE)
        else $error("decode transfer not followed by decode step");
`endif

endmodule

FILE: rtl/jbcd_datapath.sv
// datapath: item latch, dc predictors, quantizer memory, multiplier, result register
module jbcd_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  jbcd_pkg::cmd_t                  cmd,
    output jbcd_pkg::sts_t                  sts,
    input  logic [jbcd_pkg::QSEL_W-1:0]     quant_select,
    input  logic [jbcd_pkg::CHAN_W-1:0]     channel,
    input  logic [jbcd_pkg::SYM_W-1:0]      symbol,
    input  logic [jbcd_pkg::AMP_W-1:0]      amplitude,
    input  logic [jbcd_pkg::TNUM_W-1:0]     table_number,
    input  logic [jbcd_pkg::SLOT_W-1:0]     table_slot,
    input  logic [jbcd_pkg::WORD_W-1:0]     table_word,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [jbcd_pkg::POS_W-1:0]      position,
    output logic signed [jbcd_pkg::COEF_W-1:0] coefficient,
    output logic [jbcd_pkg::CHAN_W-1:0]     component,
    output logic                            last,
    output logic                            error
);
    import jbcd_pkg::*;

    localparam int ADDR_W = TNUM_W + SLOT_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    logic [WORD_W-1:0]        qmem [MEM_DEPTH];
    logic [WORD_W-1:0]        q_reg;

    logic [CHAN_W-1:0]        item_ch_reg;
    logic signed [EXT_W-1:0]  ext_reg;
    logic signed [EXT_W-1:0]  ext_next;
    logic [3:0]               run_reg;
    logic                     eob_reg;

    logic [SLOT_W-1:0]        count_reg;
    logic [3:0]               zeros_reg;
    logic signed [PRED_W-1:0] value_reg;
    logic [CHAN_W-1:0]        chan_reg;
    logic signed [PRED_W-1:0] pred_reg [CHANNEL_COUNT];

    logic                     out_valid_reg;
    logic [POS_W-1:0]         out_pos_reg;
    logic signed [COEF_W-1:0] out_coef_reg;
    logic [CHAN_W-1:0]        out_comp_reg;
    logic                     out_last_reg;
    logic                     out_err_reg;

    logic [3:0]               size;
    logic [EXT_W-1:0]         mask;
    logic [EXT_W-1:0]         amp_v;
    logic [TNUM_W-1:0]        tbl;
    logic signed [PRED_W-1:0] dc_sum;
    logic signed [PRED_W-1:0] mul_a;
    logic signed [WORD_W:0]   mul_b;
    logic signed [COEF_W:0]   prod;
    logic [7:0]               span;

    // amplitude size and jpeg sign extension of the incoming item
    always_comb
    begin
        if (count_reg == '0)
        begin
            size = (symbol > SYM_W'(SIZE_MAX)) ? SIZE_MAX : symbol[3:0];
        end
        else
        begin
            size = symbol[3:0];
        end
        mask  = (EXT_W'(1) << size) - EXT_W'(1);
        amp_v = {1'b0, amplitude} & mask;
        if (size == 4'd0)
        begin
            ext_next = '0;
        end
        else if (amp_v[size - 4'd1] == 1'b0)
        begin
            ext_next = signed'(amp_v - mask);
        end
        else
        begin
            ext_next = signed'(amp_v);
        end
    end

    // table chosen for the block's channel, saturated to the tables present
    always_comb
    begin
        tbl = quant_select[chan_reg * TNUM_W +: TNUM_W];
        if (int'(tbl) >= QUANT_TABLES)
        begin
            tbl = TNUM_W'(QUANT_TABLES - 1);
        end
    end

    assign dc_sum = pred_reg[item_ch_reg] + PRED_W'(ext_reg);
    assign mul_a  = (zeros_reg != '0) ? '0 : value_reg;
    assign mul_b  = signed'({1'b0, q_reg});
    assign prod   = mul_a * mul_b;
    assign span   = 8'(count_reg) + 8'(run_reg) + 8'd1;

    always_comb
    begin
        sts.count_zero = (count_reg == '0);
        sts.is_eob     = eob_reg;
        sts.overrun    = (span > 8'(COEFS));
        sts.ch_ok      = (int'(item_ch_reg) < CHANNEL_COUNT);
        sts.zeros_zero = (zeros_reg == '0);
        sts.count_last = (count_reg == SLOT_W'(COEFS - 1));
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // quantizer memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.q_write && int'(table_number) < QUANT_TABLES)
        begin
            qmem[{table_number, table_slot}] <= table_word;
        end
        q_reg <= qmem[{tbl, count_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_ch_reg <= channel;
            ext_reg     <= ext_next;
            run_reg     <= symbol[7:4];
            eob_reg     <= (symbol == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                pred_reg[i] <= '0;
            end
            count_reg     <= '0;
            zeros_reg     <= '0;
            chan_reg      <= '0;
            value_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.pred_clear)
            begin
                for (int i = 0; i < CHANNEL_COUNT; i++)
                begin
                    pred_reg[i] <= '0;
                end
            end
            else if (cmd.start_dc)
            begin
                pred_reg[item_ch_reg] <= dc_sum;
            end

            if (cmd.start_dc)
            begin
                chan_reg  <= item_ch_reg;
                value_reg <= dc_sum;
                zeros_reg <= '0;
            end
            else if (cmd.start_ac)
            begin
                value_reg <= PRED_W'(ext_reg);
                zeros_reg <= run_reg;
            end
            else if (cmd.start_eob)
            begin
                value_reg <= '0;
                zeros_reg <= '0;
            end
            else if (cmd.emit && zeros_reg != '0)
            begin
                zeros_reg <= zeros_reg - 4'd1;
            end

            // the six-bit count wraps to zero after the final coefficient
            if (cmd.emit)
            begin
                count_reg <= count_reg + SLOT_W'(1);
            end
            else if (cmd.emit_err)
            begin
                count_reg <= '0;
            end

            if (cmd.emit || cmd.emit_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_pos_reg  <= ZZ_TO_NAT[count_reg];
            out_coef_reg <= prod[COEF_W-1:0];
            out_comp_reg <= chan_reg;
            out_last_reg <= (count_reg == SLOT_W'(COEFS - 1));
            out_err_reg  <= 1'b0;
        end
        else if (cmd.emit_err)
        begin
            out_pos_reg  <= '0;
            out_coef_reg <= '0;
            out_comp_reg <= chan_reg;
            out_last_reg <= 1'b1;
            out_err_reg  <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign position    = out_pos_reg;
    assign coefficient = out_coef_reg;
    assign component   = out_comp_reg;
    assign last        = out_last_reg;
    assign error       = out_err_reg;

`ifndef SYNTH
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> count_reg == $past(count_reg) + SLOT_W'(1))
        else $error("coefficient count did not advance");

    a_err_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_err |=> count_reg == '0 && out_valid_reg && out_err_reg)
        else $error("overrun did not restart the block");

    a_zero_run_value: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && zeros_reg != '0) |=> out_coef_reg == '0)
        else $error("zero run gave a nonzero coefficient");
`endif

endmodule

FILE: dv/testbench.sv
// testbench for the block coefficient decoder: directed table, then random blocks
module testbench;
    import jbcd_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int IDLE_PERCENT  = 21;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 3000;
    localparam int PHASE_ITEMS   = 32;
    localparam int PHASES        = 5;
    localparam int REPORT_CAP    = 40;
    localparam int FAR_TABLE     = QUANT_TABLES - 1;
    localparam logic [2:0] QSEL_ADDR = 3'(4 * REG_QUANT_SELECT);

    typedef struct {
        op_t         op;
        logic [1:0]  ch;
        logic [7:0]  sym;
        logic [14:0] amp;
        logic [1:0]  tnum;
        logic [5:0]  slot;
        logic [15:0] word;
    } symbol_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [COEF_W-1:0] coef;
        logic [CHAN_W-1:0] comp;
        logic              last;
        logic              err;
    } coef_result_t;

    typedef struct {
        symbol_item_t item;
        bit           typed;
        coef_result_t want;
    } directed_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // channel, symbol, amplitude, table_number, table_slot, table_word, zero pad
    logic [S_DATA_W-1:0] s_axis_tdata;
    // operation
    logic [1:0]          s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // position, coefficient, component
    logic [M_DATA_W-1:0] m_axis_tdata;
    // error
    logic [0:0]          m_axis_tuser;
    logic                m_axis_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    jpeg_block_coefficient_decode dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // decoder shadow state
    logic [PRED_W-1:0] dc_pred [CHANNEL_COUNT];
    logic [WORD_W-1:0] quant_mem [256];
    int unsigned       zz_index;
    logic [1:0]        blk_chan;
    logic [QSEL_W-1:0] qsel_shadow;

    coef_result_t  pending_coefs [$];
    coef_result_t  step_coefs [$];
    directed_row_t directed_rows [$];

    int  fail_count;
    int  items_sent;
    int  coefs_checked;
    int  blocks_closed;
    int  overruns_seen;
    int  loads_sent;
    int  settings_used;
    bit  no_idle;
    bit  rx_hold_req;

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    function automatic logic signed [31:0] amp_value(logic [14:0] bits, int size);
        int v;
        if (size == 0)
            return 0;
        v = int'(bits) & ((1 << size) - 1);
        if (((v >> (size - 1)) & 1) == 0)
            return v - ((1 << size) - 1);
        return v;
    endfunction

    function automatic logic [1:0] table_for(logic [1:0] ch);
        int t;
        t = int'(qsel_shadow[2*ch +: 2]);
        if (t >= QUANT_TABLES)
            t = QUANT_TABLES - 1;
        return 2'(t);
    endfunction

    // one bit per channel: set picks the far table, clear picks table zero
    function automatic logic [7:0] two_table_select(logic [3:0] pick);
        logic [7:0] sel;
        for (int c = 0; c < CHANNEL_COUNT; c++)
            sel[2*c +: 2] = pick[c] ? 2'(FAR_TABLE) : 2'b00;
        return sel;
    endfunction

    // dequantize the coefficient at the current zigzag index and advance
    task automatic emit_coef(longint value);
        logic [5:0]   zz;
        logic [15:0]  q;
        longint       prod;
        coef_result_t r;
        zz = 6'(zz_index);
        q = quant_mem[{table_for(blk_chan), zz}];
        prod = value * longint'(q);
        zz_index++;
        r.pos = ZZ_TO_NAT[zz];
        r.coef = prod[47:0];
        r.comp = blk_chan;
        r.last = (zz_index >= COEFS);
        r.err = 1'b0;
        step_coefs.insert(step_coefs.size(), r);
        if (zz_index >= COEFS)
            zz_index = 0;
    endtask

    task automatic predict_coefficients(symbol_item_t it);
        int           run;
        int           size;
        coef_result_t r;
        step_coefs.delete();
        case (it.op)
            OP_LOAD:
                if (it.tnum < QUANT_TABLES)
                    quant_mem[{it.tnum, it.slot}] = it.word;
            OP_CLEAR:
                foreach (dc_pred[i])
                    dc_pred[i] = '0;
            OP_DECODE:
                if (zz_index == 0)
                begin
                    size = (it.sym > SIZE_MAX) ? int'(SIZE_MAX) : int'(it.sym);
                    if (it.ch < CHANNEL_COUNT)
                    begin
                        blk_chan = it.ch;
                        dc_pred[it.ch] = dc_pred[it.ch] + amp_value(it.amp, size);
                        emit_coef(longint'(signed'(dc_pred[it.ch])));
                    end
                end
                else
                begin
                    run = int'(it.sym[7:4]);
                    size = int'(it.sym[3:0]);
                    if (run == 0 && size == 0)
                    begin
                        while (zz_index != 0)
                            emit_coef(0);
                    end
                    else if (zz_index + run + 1 > COEFS)
                    begin
                        r = '{pos: '0, coef: '0, comp: blk_chan, last: 1'b1, err: 1'b1};
                        step_coefs.insert(step_coefs.size(), r);
                        zz_index = 0;
                    end
                    else
                    begin
                        repeat (run)
                            emit_coef(0);
                        emit_coef(longint'(amp_value(it.amp, size)));
                    end
                end
            default: ;
        endcase
    endtask

    function automatic symbol_item_t make_item(op_t op, logic [1:0] ch, logic [7:0] sym,
                                               logic [14:0] amp, logic [1:0] tnum,
                                               logic [5:0] slot, logic [15:0] word);
        symbol_item_t it;
        it = '{op: op, ch: ch, sym: sym, amp: amp, tnum: tnum, slot: slot, word: word};
        return it;
    endfunction

    function automatic void add_row(op_t op, logic [1:0] ch, logic [7:0] sym,
                                    logic [14:0] amp, logic [1:0] tnum = 0,
                                    logic [5:0] slot = 0, logic [15:0] word = 0,
                                    bit typed = 0, logic [5:0] pos = 0,
                                    logic [47:0] coef = 0, logic [1:0] comp = 0,
                                    logic last = 0, logic err = 0);
        directed_row_t row;
        row.item = make_item(op, ch, sym, amp, tnum, slot, word);
        row.typed = typed;
        row.want = '{pos: pos, coef: coef, comp: comp, last: last, err: err};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // mostly well-formed blocks, with loads, clears and stray items mixed in
    function automatic symbol_item_t random_item();
        symbol_item_t it;
        int           r;
        int           run;
        it = make_item(OP_DECODE, 2'($urandom), 8'($urandom), 15'($urandom),
                       2'($urandom), 6'($urandom), 16'($urandom));
        r = $urandom_range(99);
        if (r < 6)
            it.op = OP_LOAD;
        else if (r < 8)
            it.op = OP_CLEAR;
        else if (r < 10)
            it.op = OP_NONE;
        else if (zz_index == 0)
        begin
            if ($urandom_range(99) < 80)
                it.sym = 8'($urandom_range(0, 15));
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 12)
                it.sym = 8'h00;
            else if (r < 20)
                it.sym = 8'hF0;
            else if (r >= 25)
            begin
                run = $urandom_range(0, (63 - int'(zz_index)) < 15 ? 63 - int'(zz_index) : 15);
                it.sym = {4'(run), 4'($urandom_range(1, 15))};
            end
        end
        return it;
    endfunction

    task automatic send_item(symbol_item_t it);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, it.word, it.slot, it.tnum, it.amp, it.sym, it.ch};
        s_axis_tuser <= it.op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        if (it.op == OP_LOAD)
            loads_sent++;
        predict_coefficients(it);
    endtask

    // sender stops, then waits out every expected result and the block's tail
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending_coefs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_quant_select(logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= QSEL_ADDR;
        pwdata <= {24'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        qsel_shadow = value;
        settings_used++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {24'b0, value})
        begin
            fail_count++;
            $display("%0t: quant_select readback expected %0h actual %0h",
                     $time, value, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        coef_result_t want;
        coef_result_t got;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.pos = m_axis_tdata[5:0];
            got.coef = m_axis_tdata[53:6];
            got.comp = m_axis_tdata[55:54];
            got.last = m_axis_tlast;
            got.err = m_axis_tuser[0];
            if (pending_coefs.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $display("%0t: unexpected transfer expected none actual pos %0d coef %0h",
                             $time, got.pos, got.coef);
            end
            else
            begin
                want = pending_coefs.pop_front();
                check_field("position", 48'(want.pos), 48'(got.pos));
                check_field("coefficient", want.coef, got.coef);
                check_field("component", 48'(want.comp), 48'(got.comp));
                check_field("last", 48'(want.last), 48'(got.last));
                check_field("error", 48'(want.err), 48'(got.err));
            end
            coefs_checked++;
            if (got.last && !got.err)
                blocks_closed++;
            if (got.err)
                overruns_seen++;
        end
    end

    // watchdog on cycles with no transfer anywhere
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet, pending_coefs.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] qsel_plan [PHASES];
        int         filled [2];
        fail_count = 0;
        items_sent = 0;
        coefs_checked = 0;
        blocks_closed = 0;
        overruns_seen = 0;
        loads_sent = 0;
        settings_used = 0;
        no_idle = 1'b0;
        rx_hold_req = 1'b0;
        foreach (dc_pred[i])
            dc_pred[i] = '0;
        foreach (quant_mem[i])
            quant_mem[i] = '0;
        zz_index = 0;
        blk_chan = '0;
        qsel_shadow = '0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= OP_NONE;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_quant_select(8'h00);
        // table zero and the far table are filled; every quant_select used keeps to them
        filled = '{0, FAR_TABLE};
        foreach (filled[t])
            for (int s = 0; s < COEFS; s++)
                send_item(make_item(OP_LOAD, 2'($urandom), 8'($urandom), 15'($urandom),
                                    2'(filled[t]), 6'(s), 16'($urandom)));

        add_row(OP_LOAD, 0, 8'h00, 0, 0, 0, 16'd1);
        add_row(OP_LOAD, 0, 8'h00, 0, 0, 1, 16'hFFFF);
        // dc of size zero ignores its amplitude bits
        add_row(OP_DECODE, 0, 8'h00, 15'h7FFF, 0, 0, 0, 1, 0, 0, 0);
        add_row(OP_DECODE, 0, 8'h01, 15'h0001, 0, 0, 0, 1, 1, 48'd65535, 0);
        add_row(OP_DECODE, 0, 8'h00, 15'h0000);
        add_row(OP_DECODE, 1, 8'h0F, 15'h7FFF, 0, 0, 0, 1, 0, 48'd32767, 1);
        add_row(OP_DECODE, 1, 8'h0F, 15'h0000, 0, 0, 0, 1, 1, -48'sd2147385345, 1);
        add_row(OP_DECODE, 1, 8'hF0, 15'h0000);
        add_row(OP_DECODE, 1, 8'hFA, 15'h03FF);
        add_row(OP_DECODE, 1, 8'hF0, 15'h0000);
        // sixteen zeros past position 50 overruns the block
        add_row(OP_DECODE, 1, 8'hF0, 15'h0000, 0, 0, 0, 1, 0, 0, 1, 1, 1);
        // dc size above fifteen saturates
        add_row(OP_DECODE, 2, 8'd200, 15'h0000, 0, 0, 0, 1, 0, -48'sd32767, 2);
        add_row(OP_NONE, 3, 8'hFF, 15'h7FFF, 3, 63, 16'hFFFF);
        add_row(OP_CLEAR, 0, 8'h00, 0);
        add_row(OP_DECODE, 2, 8'hF0, 15'h0000);
        add_row(OP_DECODE, 2, 8'hF0, 15'h0000);
        add_row(OP_DECODE, 2, 8'hF0, 15'h0000);
        // run lands exactly on the last coefficient
        add_row(OP_DECODE, 2, 8'hE3, 15'h0005);
        add_row(OP_DECODE, 3, 8'h01, 15'h0001, 0, 0, 0, 1, 0, 48'd1, 3);
        add_row(OP_CLEAR, 0, 8'h00, 0);
        add_row(OP_DECODE, 3, 8'h00, 15'h0000);
        add_row(OP_LOAD, 0, 8'h00, 0, 3, 63, 16'h0000);
        add_row(OP_LOAD, 0, 8'h00, 0, 2, 63, 16'hFFFF);
        add_row(OP_DECODE, 0, 8'h10, 15'h4000, 0, 0, 0, 1, 0, 48'd16384, 0);
        add_row(OP_DECODE, 0, 8'h00, 15'h0000);

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].item);
            if (directed_rows[i].typed)
                pending_coefs.insert(pending_coefs.size(), directed_rows[i].want);
            else
                foreach (step_coefs[k])
                    pending_coefs.insert(pending_coefs.size(), step_coefs[k]);
        end
        drain_block();

        qsel_plan = '{two_table_select(4'hF), two_table_select(4'hA), two_table_select(4'h5),
                      two_table_select(4'($urandom)), two_table_select(4'($urandom))};
        for (int p = 0; p < PHASES; p++)
        begin
            write_quant_select(qsel_plan[p]);
            no_idle = (p == 1);
            if (p == 3)
                rx_hold_req = 1'b1;
            repeat (PHASE_ITEMS)
            begin
                send_item(random_item());
                foreach (step_coefs[k])
                    pending_coefs.insert(pending_coefs.size(), step_coefs[k]);
            end
            no_idle = 1'b0;
            drain_block();
        end

        $display("sent %0d items (%0d quantizer loads) under %0d quant_select settings",
                 items_sent, loads_sent, settings_used);
        $display("checked %0d coefficients: %0d full blocks, %0d run overruns",
                 coefs_checked, blocks_closed, overruns_seen);
        if (fail_count == 0 && pending_coefs.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/jbcd_pkg.sv
rtl/jbcd_ctrl.sv
rtl/jbcd_datapath.sv
rtl/jpeg_block_coefficient_decode.sv
dv/testbench.sv
